[rtl/core/amd_pkg.sv]
// ----------------------------------------------------------------------------
// amd_pkg
// shared widths, mode codes and the axis command struct of the motion alarm
// ----------------------------------------------------------------------------
package amd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int TOL_W       = 10;
   localparam int CAL_SAMPLES = 50;
   localparam int CAL_CNT_W   = 6;
   localparam int MODE_W      = 3;

   // window limits need room for the bound plus or minus the full tolerance
   localparam int LIMIT_W = ((SAMPLE_W > TOL_W) ? SAMPLE_W : TOL_W) + 2;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

   localparam logic [MODE_W-1:0] MODE_IDLE     = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_CAL      = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_ARMED    = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_ALARM    = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_DISARMED = MODE_W'(4);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic seed;
      logic widen;
      logic check;
   } axis_cmd_type;

endpackage

[rtl/core/amd_axis.sv]
// ----------------------------------------------------------------------------
// amd_axis
// calibrated bounds of one axis: seed, widen and window check
// ----------------------------------------------------------------------------
module amd_axis (
   input  logic                      clock,
   input  logic                      reset,
   input  amd_pkg::axis_cmd_type     cmd,
   input  amd_pkg::sample_type       sample,
   input  logic [amd_pkg::TOL_W-1:0] tolerance,
   output logic                      motion
);
   import amd_pkg::*;

   sample_type low_ff, low_in;
   sample_type high_ff, high_in;

   logic signed [LIMIT_W-1:0] upper_lim;
   logic signed [LIMIT_W-1:0] lower_lim;
   logic signed [LIMIT_W-1:0] sample_ext;
   logic signed [LIMIT_W-1:0] tol_ext;

   always_comb begin
      sample_ext = LIMIT_W'(sample);
      tol_ext    = $signed({{(LIMIT_W-TOL_W){1'b0}}, tolerance});
      upper_lim  = LIMIT_W'(high_ff) + tol_ext;
      lower_lim  = LIMIT_W'(low_ff) - tol_ext;
      motion     = cmd.check && ((sample_ext > upper_lim) || (sample_ext < lower_lim));
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (cmd.seed) begin
         low_in  = sample;
         high_in = sample;
      end else if (cmd.widen) begin
         // only one side moves per sample
         if (sample > high_ff) begin
            high_in = sample;
         end else if (sample < low_ff) begin
            low_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

[rtl/core/amd_ctl.sv]
// ----------------------------------------------------------------------------
// amd_ctl
// mode sequencer: calibration count, arming, alarm latch and disarm
// ----------------------------------------------------------------------------
module amd_ctl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       cal_req,
   input  logic                       disarm,
   input  logic                       motion_any,
   output amd_pkg::axis_cmd_type      axis_cmd,
   output logic [amd_pkg::MODE_W-1:0] mode,
   output logic                       alarm_level
);
   import amd_pkg::*;

   typedef enum logic [MODE_W-1:0] {
      ST_IDLE     = MODE_IDLE,
      ST_CAL      = MODE_CAL,
      ST_ARMED    = MODE_ARMED,
      ST_ALARM    = MODE_ALARM,
      ST_DISARMED = MODE_DISARMED
   } mode_type;

   localparam logic [CAL_CNT_W-1:0] CAL_LAST = CAL_CNT_W'(CAL_SAMPLES);

   mode_type             mode_ff, mode_in;
   logic [CAL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 alarm_ff, alarm_in;

   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      alarm_in = alarm_ff;
      axis_cmd = '0;
      if (step) begin
         unique case (mode_ff) inside
            ST_DISARMED: begin
            end
            ST_CAL: begin
               axis_cmd.widen = 1'b1;
               cnt_in         = cnt_ff + 1'b1;
               // a wrapped count also ends calibration
               if ((cnt_in >= CAL_LAST) || (cnt_in == '0)) begin
                  mode_in = ST_ARMED;
               end
            end
            ST_IDLE, ST_ARMED, ST_ALARM: begin
               if (disarm) begin
                  mode_in  = ST_DISARMED;
                  alarm_in = 1'b0;
               end else if (cal_req) begin
                  axis_cmd.seed = 1'b1;
                  cnt_in        = '0;
                  mode_in       = ST_CAL;
               end else if (mode_ff == ST_ARMED) begin
                  axis_cmd.check = 1'b1;
                  if (motion_any) begin
                     mode_in  = ST_ALARM;
                     alarm_in = 1'b1;
                  end
               end
            end
            default: begin
               mode_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ST_IDLE;
         cnt_ff   <= '0;
         alarm_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         alarm_ff <= alarm_in;
      end
   end

   assign mode        = mode_ff;
   assign alarm_level = alarm_ff;

   a_disarm_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ST_DISARMED |=> mode_ff == ST_DISARMED)
      else $error("left disarmed mode");

   a_disarm_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ST_DISARMED |-> !alarm_ff)
      else $error("alarm high while disarmed");

   a_alarm_level: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ST_ALARM |-> alarm_ff)
      else $error("alarm mode without alarm level");

   a_cal_bounded: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ST_CAL |-> cnt_ff < CAL_LAST)
      else $error("calibration count overran");

endmodule

[rtl/core/accel_motion_alarm_top.sv]
// ----------------------------------------------------------------------------
// accel_motion_alarm_top
// accelerometer motion alarm with min/max calibration window
// ----------------------------------------------------------------------------
// usage
//   req_*  : one three-axis sample word with calibrate and remote disarm flags,
//            valid/ready handshake
//   rsp_*  : one result word per request word: mode, alarm pin level,
//            acknowledge request and per-axis motion flags, valid/ready
//   csr_*  : write-only tolerance register, taken on csr_write_enable
// stages: two register stages, the input register and then the state and
//   result register
// throughput: one word per cycle while rsp_ready is high; the mode and bound
//   update is combinational compare and select after the input register
// reset: mode idle, bounds and calibration count zero, alarm low, tolerance 10,
//   both pipeline stages empty
// stall: while rsp_ready is low the result is held; one further word is held
//   in the input register, after which req_ready drops
// the tolerance register must only be written while the block is empty
// ----------------------------------------------------------------------------
module accel_motion_alarm_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  amd_pkg::sample_type        req_accel_x,
   input  amd_pkg::sample_type        req_accel_y,
   input  amd_pkg::sample_type        req_accel_z,
   input  logic                       req_calibrate_request,
   input  logic                       req_remote_disarm,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [amd_pkg::MODE_W-1:0] rsp_mode,
   output logic                       rsp_alarm_out,
   output logic                       rsp_send_ack,
   output logic                       rsp_motion_x,
   output logic                       rsp_motion_y,
   output logic                       rsp_motion_z,
   // configuration
   input  logic                       csr_write_enable,
   input  logic [amd_pkg::TOL_W-1:0]  csr_write_data
);
   import amd_pkg::*;

   // tolerance register
   logic [TOL_W-1:0] tol_ff;

   // input register stage
   logic       in_valid_ff, in_valid_in;
   sample_type x_ff, y_ff, z_ff;
   logic       cal_ff, disarm_ff;

   // result register stage (mode and alarm live in the sequencer)
   logic       out_valid_ff, out_valid_in;
   logic [2:0] motion_ff;

   logic         advance;
   logic         accept;
   axis_cmd_type axis_cmd;
   logic [2:0]   motion;
   logic [MODE_W-1:0] mode;
   logic         alarm_level;

   // the input word moves on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff      <= req_accel_x;
         y_ff      <= req_accel_y;
         z_ff      <= req_accel_z;
         cal_ff    <= req_calibrate_request;
         disarm_ff <= req_remote_disarm;
      end
      if (advance) begin
         motion_ff <= motion;
      end
   end

   amd_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .cal_req     (cal_ff),
      .disarm      (disarm_ff),
      .motion_any  (|motion),
      .axis_cmd    (axis_cmd),
      .mode        (mode),
      .alarm_level (alarm_level)
   );

   amd_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .cmd       (axis_cmd),
      .sample    (x_ff),
      .tolerance (tol_ff),
      .motion    (motion[0])
   );

   amd_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .cmd       (axis_cmd),
      .sample    (y_ff),
      .tolerance (tol_ff),
      .motion    (motion[1])
   );

   amd_axis u_axis_z (
      .clock     (clock),
      .reset     (reset),
      .cmd       (axis_cmd),
      .sample    (z_ff),
      .tolerance (tol_ff),
      .motion    (motion[2])
   );

   // mode and alarm change only when a new result is loaded, so they serve
   // directly as the result fields
   assign rsp_valid     = out_valid_ff;
   assign rsp_mode      = mode;
   assign rsp_alarm_out = alarm_level;
   assign rsp_send_ack  = (mode == MODE_DISARMED);
   assign rsp_motion_x  = motion_ff[0];
   assign rsp_motion_y  = motion_ff[1];
   assign rsp_motion_z  = motion_ff[2];

   a_motion_alarms: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (|motion_ff) |-> mode == MODE_ALARM && alarm_level)
      else $error("motion reported without alarm");

   a_no_lost_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("held input word dropped");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word gave no result");

endmodule

[verif/accel_motion_alarm_checker.sv]
// ----------------------------------------------------------------------------
// accel_motion_alarm_checker
// watches the request, result and csr ports of the motion alarm, keeps its own
// copy of mode, per-axis bounds, calibration count, alarm pin and tolerance,
// predicts the result of every accepted request word and compares it with the
// result words in order
// ----------------------------------------------------------------------------
module accel_motion_alarm_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  amd_pkg::sample_type          req_accel_x,
   input  amd_pkg::sample_type          req_accel_y,
   input  amd_pkg::sample_type          req_accel_z,
   input  logic                         req_calibrate_request,
   input  logic                         req_remote_disarm,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [amd_pkg::MODE_W-1:0]   rsp_mode,
   input  logic                         rsp_alarm_out,
   input  logic                         rsp_send_ack,
   input  logic                         rsp_motion_x,
   input  logic                         rsp_motion_y,
   input  logic                         rsp_motion_z,
   input  logic                         csr_write_enable,
   input  logic [amd_pkg::TOL_W-1:0]    csr_write_data,
   output int                           mismatches,
   output int                           pending,
   output int                           results_checked,
   output int                           alarms_raised
);
   import amd_pkg::*;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              alarm_out;
      logic              send_ack;
      logic              motion_x;
      logic              motion_y;
      logic              motion_z;
   } alarm_result_type;

   logic [MODE_W-1:0]    mode_q;
   sample_type           lo_q [3];
   sample_type           hi_q [3];
   logic [CAL_CNT_W-1:0] cal_count_q;
   logic                 alarm_q;
   logic [TOL_W-1:0]     tol_q;
   alarm_result_type     expected_q [$];

   // window test with full integer range, no wrap
   function automatic bit leaves_window(sample_type s, sample_type lo, sample_type hi);
      int v;
      int l;
      int h;
      int t;
      v = s;
      l = lo;
      h = hi;
      t = tol_q;
      return (v > h + t) || (v < l - t);
   endfunction

   function automatic alarm_result_type step_alarm(input sample_type x, y, z,
                                                   input logic cal, dis);
      sample_type       smp [3];
      logic [2:0]       hit;
      alarm_result_type r;
      smp[0] = x;
      smp[1] = y;
      smp[2] = z;
      hit    = '0;
      if (mode_q == MODE_DISARMED) begin
         // locked until reset
      end else if (mode_q == MODE_CAL) begin
         for (int a = 0; a < 3; a++) begin
            if (smp[a] > hi_q[a]) hi_q[a] = smp[a];
            else if (smp[a] < lo_q[a]) lo_q[a] = smp[a];
         end
         cal_count_q = cal_count_q + 1'b1;
         if (cal_count_q >= CAL_SAMPLES || cal_count_q == '0) mode_q = MODE_ARMED;
      end else if (dis) begin
         mode_q  = MODE_DISARMED;
         alarm_q = 1'b0;
      end else if (cal) begin
         for (int a = 0; a < 3; a++) begin
            lo_q[a] = smp[a];
            hi_q[a] = smp[a];
         end
         cal_count_q = '0;
         mode_q      = MODE_CAL;
      end else if (mode_q == MODE_ARMED) begin
         for (int a = 0; a < 3; a++) hit[a] = leaves_window(smp[a], lo_q[a], hi_q[a]);
         if (|hit) begin
            mode_q  = MODE_ALARM;
            alarm_q = 1'b1;
         end
      end else if (mode_q == MODE_ALARM) begin
         alarm_q = 1'b1;
      end else begin
         mode_q = MODE_IDLE;
      end
      r.mode      = mode_q;
      r.alarm_out = alarm_q;
      r.send_ack  = (mode_q == MODE_DISARMED);
      r.motion_x  = hit[0];
      r.motion_y  = hit[1];
      r.motion_z  = hit[2];
      return r;
   endfunction

   function void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      alarm_result_type want;
      if (reset) begin
         mode_q      = MODE_IDLE;
         cal_count_q = '0;
         alarm_q     = 1'b0;
         tol_q       = TOL_RESET;
         for (int a = 0; a < 3; a++) begin
            lo_q[a] = '0;
            hi_q[a] = '0;
         end
         expected_q.delete();
      end else begin
         if (csr_write_enable) tol_q = csr_write_data;
         // a result at this edge always belongs to an earlier word
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("result word with nothing expected: mode %0d", rsp_mode);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("mode", want.mode, rsp_mode);
               check_field("alarm_out", want.alarm_out, rsp_alarm_out);
               check_field("send_ack", want.send_ack, rsp_send_ack);
               check_field("motion_x", want.motion_x, rsp_motion_x);
               check_field("motion_y", want.motion_y, rsp_motion_y);
               check_field("motion_z", want.motion_z, rsp_motion_z);
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            want = step_alarm(req_accel_x, req_accel_y, req_accel_z,
                              req_calibrate_request, req_remote_disarm);
            if (want.motion_x | want.motion_y | want.motion_z) alarms_raised++;
            expected_q.push_back(want);
         end
      end
      pending = expected_q.size();
   end

endmodule

[verif/accel_motion_alarm_top_tb.sv]
// ----------------------------------------------------------------------------
// accel_motion_alarm_top_tb
// drives sample words, tolerance writes and result back-pressure into the
// motion alarm; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module accel_motion_alarm_top_tb;
   import amd_pkg::*;

   // generous bound, real runs need a small fraction of this
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int WORD_TARGET = 1740;
   localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));

   logic               clock                 = 1'b0;
   logic               reset                 = 1'b1;
   logic               req_valid             = 1'b0;
   sample_type         req_accel_x           = '0;
   sample_type         req_accel_y           = '0;
   sample_type         req_accel_z           = '0;
   logic               req_calibrate_request = 1'b0;
   logic               req_remote_disarm     = 1'b0;
   logic               rsp_ready             = 1'b0;
   logic               csr_write_enable      = 1'b0;
   logic [TOL_W-1:0]   csr_write_data        = '0;
   logic               req_ready;
   logic               rsp_valid;
   logic [MODE_W-1:0]  rsp_mode;
   logic               rsp_alarm_out;
   logic               rsp_send_ack;
   logic               rsp_motion_x;
   logic               rsp_motion_y;
   logic               rsp_motion_z;

   int mismatches;
   int pending;
   int results_checked;
   int alarms_raised;

   // stimulus bookkeeping
   int words_sent   = 0;
   int tol_writes   = 0;
   int cycle_count  = 0;
   int tol_now      = TOL_RESET;
   bit no_gaps      = 1'b0;
   // bounds the block should have learnt from the last calibration we sent
   int win_lo [3];
   int win_hi [3];

   always #1 clock = ~clock;

   accel_motion_alarm_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_accel_x           (req_accel_x),
      .req_accel_y           (req_accel_y),
      .req_accel_z           (req_accel_z),
      .req_calibrate_request (req_calibrate_request),
      .req_remote_disarm     (req_remote_disarm),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_alarm_out         (rsp_alarm_out),
      .rsp_send_ack          (rsp_send_ack),
      .rsp_motion_x          (rsp_motion_x),
      .rsp_motion_y          (rsp_motion_y),
      .rsp_motion_z          (rsp_motion_z),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   accel_motion_alarm_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_accel_x           (req_accel_x),
      .req_accel_y           (req_accel_y),
      .req_accel_z           (req_accel_z),
      .req_calibrate_request (req_calibrate_request),
      .req_remote_disarm     (req_remote_disarm),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_alarm_out         (rsp_alarm_out),
      .rsp_send_ack          (rsp_send_ack),
      .rsp_motion_x          (rsp_motion_x),
      .rsp_motion_y          (rsp_motion_y),
      .rsp_motion_z          (rsp_motion_z),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .mismatches            (mismatches),
      .pending               (pending),
      .results_checked       (results_checked),
      .alarms_raised         (alarms_raised)
   );

   // mostly no pause or a short one, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_int(int v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // full-range sample, every bit of the field gets exercised
   function automatic int any_sample();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   function automatic int near(int centre, int spread);
      return clamp_int(centre + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // one request word; valid stays up from the previous word when there is no gap
   task automatic send_word(input int x, y, z, input bit cal, dis);
      int gap;
      gap = no_gaps ? 0 : pick_pause();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_accel_x           <= sample_type'(x);
      req_accel_y           <= sample_type'(y);
      req_accel_z           <= sample_type'(z);
      req_calibrate_request <= cal;
      req_remote_disarm     <= dis;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // hold the sender until every predicted result has come back
   task automatic drain();
      release_req();
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_tolerance(input int value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[TOL_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tol_now = value;
      tol_writes++;
   endtask

   // seed word plus the full calibration stretch; flag noise is ignored there
   task automatic calibrate_run(input int cx, cy, cz, input int spread, input bit flag_noise);
      int centre [3];
      int v [3];
      centre[0] = cx;
      centre[1] = cy;
      centre[2] = cz;
      for (int a = 0; a < 3; a++) begin
         v[a]      = near(centre[a], spread);
         win_lo[a] = v[a];
         win_hi[a] = v[a];
      end
      send_word(v[0], v[1], v[2], 1'b1, 1'b0);
      repeat (CAL_SAMPLES) begin
         for (int a = 0; a < 3; a++) begin
            v[a] = near(centre[a], spread);
            if (v[a] < win_lo[a]) win_lo[a] = v[a];
            if (v[a] > win_hi[a]) win_hi[a] = v[a];
         end
         send_word(v[0], v[1], v[2],
                   flag_noise && ($urandom_range(0, 3) == 0),
                   flag_noise && ($urandom_range(0, 3) == 0));
      end
   endtask

   // armed words inside the learnt window, some probing its edges on one axis
   task automatic armed_run(input int n, input int probe_pct);
      int v [3];
      int a;
      repeat (n) begin
         for (int k = 0; k < 3; k++)
            v[k] = win_lo[k] + int'($urandom_range(0, win_hi[k] - win_lo[k]));
         if ($urandom_range(0, 99) < probe_pct) begin
            a = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
               0: v[a] = win_lo[a] - tol_now - 1;
               1: v[a] = win_lo[a] - tol_now;
               2: v[a] = win_hi[a] + tol_now;
               default: v[a] = win_hi[a] + tol_now + 1;
            endcase
            v[a] = clamp_int(v[a]);
         end
         send_word(v[0], v[1], v[2], 1'b0, 1'b0);
      end
   endtask

   // anything goes except a disarm, which would end the run's useful life
   task automatic noise_run(input int n);
      repeat (n)
         send_word(any_sample(), any_sample(), any_sample(),
                   $urandom_range(0, 9) == 0, 1'b0);
   endtask

   // result side back-pressure: ready stretches, some very long, then stalls
   initial begin : result_sink
      int n;
      @(negedge reset);
      forever begin
         n = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12);
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         n = pick_pause();
         repeat (n) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      // synchronous reset held, then released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle after reset: extreme samples, no flags, mode must stay idle
      send_word(SAMPLE_MIN, SAMPLE_MAX, 0, 1'b0, 1'b0);
      send_word(SAMPLE_MAX, SAMPLE_MIN, -1, 1'b0, 1'b0);
      send_word(-1, 0, SAMPLE_MAX, 1'b0, 1'b0);

      // first calibration at the reset tolerance, flags during it are ignored
      calibrate_run(0, 0, 0, 100, 1'b1);
      // exactly on every window edge: no motion
      send_word(win_hi[0] + tol_now, win_lo[1] - tol_now, win_hi[2] + tol_now,
                1'b0, 1'b0);
      send_word(win_lo[0] - tol_now, win_hi[1] + tol_now, win_lo[2] - tol_now,
                1'b0, 1'b0);
      // one past the edge on all axes at once: alarm with three motion flags
      send_word(win_hi[0] + tol_now + 1, win_lo[1] - tol_now - 1,
                win_hi[2] + tol_now + 1, 1'b0, 1'b0);
      // alarm mode holds the pin on a quiet word
      send_word(0, 0, 0, 1'b0, 1'b0);

      // recalibrate while alarmed over the whole sample range, pin stays high
      calibrate_run(0, 0, 0, SAMPLE_MAX, 1'b0);
      armed_run(4, 100);

      // tolerance extremes, each with its own calibration
      write_tolerance(0);
      calibrate_run(any_sample(), any_sample(), any_sample(), 3, 1'b0);
      armed_run(20, 30);
      write_tolerance((1 << TOL_W) - 1);
      calibrate_run(SAMPLE_MIN, SAMPLE_MAX, 0, 200, 1'b1);
      armed_run(20, 30);

      // random phases of well-formed calibrate/armed runs mixed with noise
      while (words_sent < WORD_TARGET) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9)) inside
            0: write_tolerance($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                    : $urandom_range(0, 1023));
            1: drain();
            2, 3: noise_run($urandom_range(1, 25));
            default: begin
               calibrate_run(any_sample(), any_sample(), any_sample(),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(0, 60),
                             1'($urandom_range(0, 1)));
               armed_run($urandom_range(5, 40), 10);
            end
         endcase
      end

      // disarm is permanent, so it only comes at the very end; a clean
      // calibration first makes sure it lands in armed or alarm mode
      no_gaps = 1'b0;
      calibrate_run(any_sample(), any_sample(), any_sample(), 50, 1'b0);
      armed_run(6, 40);
      // disarm beats a calibrate request on the same word
      send_word(any_sample(), any_sample(), any_sample(), 1'($urandom_range(0, 1)), 1'b1);
      // disarmed: flags and samples ignored, acknowledge on every word
      repeat (20)
         send_word(any_sample(), any_sample(), any_sample(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

      drain();
      // wait on for any stray result after the drain
      repeat (10) @(negedge clock);

      $display("summary: %0d sample words, %0d results checked, %0d motion alarms",
               words_sent, results_checked, alarms_raised);
      $display("summary: %0d tolerance writes incl. both extremes, ended in disarmed mode",
               tol_writes);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/core/amd_pkg.sv
rtl/core/amd_axis.sv
rtl/core/amd_ctl.sv
rtl/core/accel_motion_alarm_top.sv
verif/accel_motion_alarm_checker.sv
verif/accel_motion_alarm_top_tb.sv
